### hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned DATA_W = 30;
  localparam int unsigned PROD_W = 2 * DATA_W;

  // Fixed prime modulus and its Barrett constant floor(2^60 / P).
  localparam logic [DATA_W-1:0] PRIME_MOD = 30'd1000000007;
  localparam logic [30:0]       BARRETT_MU =
      31'((64'd1 << PROD_W) / 64'(PRIME_MOD));

  // Phase at which the sequencer steps, once a multiply has left the pipeline.
  localparam logic [1:0] STEP_PHASE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
  } dp_status_t;

endpackage

### hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod 1000000007 by right-to-left square and multiply.
// ----------------------------------------------------------------------------
//   Channel  | Ports                  | Handshake
//   ---------+------------------------+------------------------------------
//   input    | base_i, exponent_i     | taken when start_i=1 and busy_o=0
//   result   | power_o                | valid for one cycle while done_o=1
//
// The accumulator and square multipliers run in parallel through a 3-stage
// multiply and Barrett reduction pipeline, and the sequencer steps once per
// exponent bit up to the highest set bit among the low EXP_BITS exponent bits.
// Reset clears only the sequencer; one item is in flight at a time.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [29:0] base_i,
  input  logic [31:0] exponent_i,
  output logic        done_o,
  output logic [29:0] power_o
);
  import modexp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  modexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  modexp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .power_o    (power_o)
  );

endmodule

### hw/rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// Three-stage multiplier with Barrett reduction modulo the fixed prime.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  logic        clk_i,
  input  logic [29:0] a_i,
  input  logic [29:0] b_i,
  output logic [29:0] y_o
);
  import modexp_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [31:0]       prod_lo_q;
  logic [30:0]       quot_q;
  logic [31:0]       rem_q;
  logic [61:0]       quot_full;
  logic [60:0]       qp_full;
  logic [31:0]       rem_d;
  logic [31:0]       two_p;

  assign quot_full = 62'(prod_q[PROD_W-1:29]) * 62'(BARRETT_MU);
  assign qp_full   = 61'(quot_q) * 61'(PRIME_MOD);
  assign rem_d     = prod_lo_q - qp_full[31:0];
  assign two_p     = {1'b0, PRIME_MOD, 1'b0};

  always_ff @(posedge clk_i) begin
    prod_q    <= PROD_W'(a_i) * PROD_W'(b_i);
    prod_lo_q <= prod_q[31:0];
    quot_q    <= quot_full[61:31];
    rem_q     <= rem_d;
  end

  // The Barrett estimate leaves a remainder below three times the modulus.
  always_comb begin
    if (rem_q >= two_p) begin
      y_o = 30'(rem_q - two_p);
    end else if (rem_q >= 32'(PRIME_MOD)) begin
      y_o = 30'(rem_q - 32'(PRIME_MOD));
    end else begin
      y_o = rem_q[29:0];
    end
  end

endmodule

### hw/rtl/modexp_datapath.sv
// ----------------------------------------------------------------------------
// modexp_datapath
// Accumulator, square and exponent registers with two modular multipliers.
// ----------------------------------------------------------------------------
module modexp_datapath #(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic                    clk_i,
  input  modexp_pkg::dp_cmd_t     cmd_i,
  output modexp_pkg::dp_status_t  status_o,
  input  logic [29:0]             base_i,
  input  logic [31:0]             exponent_i,
  output logic [29:0]             power_o
);
  import modexp_pkg::*;

  localparam int unsigned EXT_W = (EXP_BITS > 32) ? EXP_BITS : 32;

  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [DATA_W-1:0]   sq_q, sq_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [EXT_W-1:0]    exp_ext;
  logic [DATA_W-1:0]   base_red;
  logic [DATA_W-1:0]   acc_prod;
  logic [DATA_W-1:0]   sq_prod;

  assign exp_ext  = EXT_W'(exponent_i);
  assign base_red = (base_i >= PRIME_MOD) ? (base_i - PRIME_MOD) : base_i;

  modexp_mulmod u_acc_mul (
    .clk_i (clk_i),
    .a_i   (acc_q),
    .b_i   (sq_q),
    .y_o   (acc_prod)
  );

  modexp_mulmod u_sq_mul (
    .clk_i (clk_i),
    .a_i   (sq_q),
    .b_i   (sq_q),
    .y_o   (sq_prod)
  );

  always_comb begin
    acc_d = acc_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    if (cmd_i.load) begin
      acc_d = DATA_W'(1);
      sq_d  = base_red;
      exp_d = exp_ext[EXP_BITS-1:0];
    end else if (cmd_i.step) begin
      if (exp_q[0]) begin
        acc_d = acc_prod;
      end
      sq_d  = sq_prod;
      exp_d = exp_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign power_o           = acc_q;

endmodule

### hw/rtl/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer: loads an item, steps once per exponent bit, strobes the result.
// ----------------------------------------------------------------------------
module modexp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  output logic                    done_o,
  output modexp_pkg::dp_cmd_t     cmd_o,
  input  modexp_pkg::dp_status_t  status_i
);
  import modexp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    done_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          phase_d    = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        // Once no set bit is left the accumulator holds the final power.
        if (status_i.exp_zero) begin
          state_d = ST_DONE;
        end else if (phase_q == STEP_PHASE) begin
          cmd_o.step = 1'b1;
          phase_d    = '0;
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### tb/sv/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Drives base/exponent items into the modular exponentiation block with random
// idle gaps and checks every power strobe against a square-and-multiply model
// computed with 64-bit arithmetic modulo the fixed prime.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

  localparam int unsigned EXP_BITS      = 32;
  localparam int unsigned SETTLE_CYCLES = 4 * EXP_BITS + 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam logic [63:0] MODULUS       = 64'(modexp_pkg::PRIME_MOD);
  localparam logic [29:0] BASE_MAX      = 30'h3FFF_FFFF;

  typedef struct {
    logic [29:0] base;
    logic [31:0] exponent;
    int unsigned gap;    // idle cycles before the item is offered
    bit          drain;  // hold the item back until every power has come
  } pow_request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [29:0] base_i = '0;
  logic [31:0] exponent_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [29:0] power_o;

  pow_request_t request_q[$];
  logic [29:0]  expected_powers[$];
  int unsigned  idle_cnt = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;

  modular_exponentiation #(
    .EXP_BITS(EXP_BITS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .base_i    (base_i),
    .exponent_i(exponent_i),
    .done_o    (done_o),
    .power_o   (power_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Right-to-left square and multiply; an unreduced base is folded first.
  function automatic logic [29:0] predict_power(logic [29:0] b, logic [31:0] e);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = 64'(b) % MODULUS;
    acc = 64'd1;
    for (int i = 0; i < EXP_BITS && i < 32; i++) begin
      if (e[i]) begin
        acc = (acc * sq) % MODULUS;
      end
      sq = (sq * sq) % MODULUS;
    end
    return acc[29:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  task automatic add_request(logic [29:0] b, logic [31:0] e, int unsigned gap, bit drain);
    pow_request_t req;
    req.base     = b;
    req.exponent = e;
    req.gap      = gap;
    req.drain    = drain;
    request_q.insert(request_q.size(), req);
  endtask

  // Driver: an item is taken at an edge where start_i is high and busy_o low.
  always @(posedge clk_i) begin
    pow_request_t nxt;
    bit           fire;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      idle_cnt = 0;
    end else begin
      fire = start_i && !busy_o;
      if (fire) begin
        expected_powers.insert(expected_powers.size(), predict_power(base_i, exponent_i));
      end
      if (!start_i || fire) begin
        if (request_q.size() != 0 && idle_cnt >= request_q[0].gap &&
            !(request_q[0].drain && expected_powers.size() != 0)) begin
          nxt = request_q.pop_front();
          start_i    <= 1'b1;
          base_i     <= nxt.base;
          exponent_i <= nxt.exponent;
          idle_cnt = 0;
        end else begin
          start_i <= 1'b0;
          idle_cnt++;
        end
      end
    end
  end

  // Monitor: the strobe cannot be held off, so every done_o edge is a result.
  always @(posedge clk_i) begin
    logic [29:0] want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("power %0d with no item pending", power_o));
      end else begin
        want = expected_powers.pop_front();
        if (power_o !== want) begin
          report_mismatch($sformatf("power got %0d, expected %0d", power_o, want));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [29:0] b;
    logic [31:0] e;
    int unsigned gap;
    int unsigned burst_left;
    bit          drain;

    // Directed items: zero exponent, extremes, unreduced bases, Fermat cases.
    add_request(30'd0, 32'd0, 0, 1'b0);
    add_request(30'd5, 32'd0, 0, 1'b0);
    add_request(BASE_MAX, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(30'(MODULUS), 32'd5, 1, 1'b0);
    add_request(30'(MODULUS + 1), 32'hDEAD_BEEF, 0, 1'b0);
    add_request(30'(MODULUS - 1), 32'(MODULUS - 2), 0, 1'b0);
    add_request(30'd2, 32'(MODULUS - 2), 3, 1'b0);
    add_request(30'd0, 32'd1, 0, 1'b0);
    add_request(30'd1, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(30'(MODULUS - 1), 32'd1, 0, 1'b0);
    add_request(30'd7, 32'h8000_0000, 2, 1'b0);
    add_request(30'd123456789, 32'(MODULUS - 1), 0, 1'b0);
    add_request(30'd3, 32'hAAAA_AAAA, 0, 1'b0);
    add_request(30'h2AAA_AAAA, 32'h5555_5555, 0, 1'b0);
    add_request(BASE_MAX, 32'h8000_0000, 0, 1'b0);
    add_request(30'd2, 32'd31, 5, 1'b0);
    add_request(30'(MODULUS - 1), 32'd0, 0, 1'b0);
    add_request(30'd0, 32'hFFFF_FFFF, 0, 1'b0);

    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: b = 30'($urandom_range(32'(MODULUS - 1)));
        7:       b = 30'($urandom_range(32'(BASE_MAX), 32'(MODULUS)));
        8:       b = ($urandom_range(1) == 0) ? 30'($urandom_range(1)) : 30'(MODULUS - 1);
        default: b = 30'($urandom);
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: e = $urandom;
        4, 5, 6:    e = $urandom >> $urandom_range(31, 1);
        7:          e = 32'(MODULUS - 2 + $urandom_range(1));
        8:          e = 32'd1 << $urandom_range(31);
        default:    e = $urandom_range(3);
      endcase
      // Runs of back-to-back items alternate with mostly short, sometimes long gaps.
      if (burst_left != 0) begin
        burst_left--;
        gap = 0;
      end else begin
        case ($urandom_range(19))
          0:          begin burst_left = $urandom_range(30, 5); gap = 0; end
          1, 2:       gap = $urandom_range(60, 15);
          3, 4, 5, 6: gap = $urandom_range(10, 3);
          default:    gap = $urandom_range(2);
        endcase
      end
      drain = (n == 0) || ($urandom_range(49) == 0);
      add_request(b, e, gap, drain);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start_i || expected_powers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
